@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the priority queue.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("priority queue check failed");

// Plain clocked check that also runs during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("priority queue check failed");

`endif

@@ rtl/sspq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// Depends on nothing; imported by the interfaces, the cells and the top level.
package sspq_pkg;

    localparam int PRIO_W        = 32;
    localparam int OCC_W         = 7;
    localparam int DEFAULT_DEPTH = 64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Command broadcast from the top level to every cell
    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [PRIO_W-1:0] prio;
    } cmd_t;

endpackage

@@ rtl/sspq_req_if.sv @@
// Request and response channel interfaces of the priority queue.
// Depends on sspq_pkg.
interface sspq_req_if import sspq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [PRIO_W-1:0] priority_req;

    modport source(output valid, opcode, priority_req, input ready);
    modport sink(input valid, opcode, priority_req, output ready);
endinterface

interface sspq_rsp_if import sspq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PRIO_W-1:0] popped_priority;
    logic [1:0]        status;
    logic [OCC_W-1:0]  occupancy;

    modport source(output valid, popped_priority, status, occupancy, input ready);
    modport sink(input valid, popped_priority, status, occupancy, output ready);
endinterface

@@ rtl/stable_sorted_priority_queue.sv @@
// Stable sorted priority queue: min-priority queue kept as a chain of sorted cells.
// Depends on sspq_pkg, sspq_req_if/sspq_rsp_if and sspq_cell.
// Use:
//   req channel carries opcode (0 insert, 1 pop) and a 32-bit priority_req.
//   rsp channel returns one item per request: popped_priority, status
//   (ok, pop from empty, insert dropped because full) and the occupancy
//   after the operation.
//   Every cell compares the broadcast priority with its own entry; cells at
//   and after the insert point shift one place right, a pop shifts the whole
//   chain one place left. Equal priorities leave in arrival order.
// Timing:
//   rsp valid rises in the cycle after the req transfer. One request is
//   taken every cycle as long as the response register drains; the rate is
//   set by the single response register in front of rsp.
// Reset:
//   rst_n clears the entry count and the response valid; the cells hold
//   stale data that is never read.
// Stall:
//   When rsp is held off, the pending result stays in its register and req
//   ready drops until it is transferred.
module stable_sorted_priority_queue import sspq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    sspq_req_if.sink   req,
    sspq_rsp_if.source rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]     count_reg, count_next;
    logic              rsp_valid_reg;
    logic [PRIO_W-1:0] popped_reg, popped_next;
    status_t           status_reg, status_next;
    logic [OCC_W-1:0]  occ_reg;

    logic accept;
    logic full;
    logic empty;
    cmd_t cmd;

    logic [PRIO_W-1:0] cell_value [QUEUE_DEPTH];
    logic              cell_take  [QUEUE_DEPTH];

    // Accept a request whenever the response register is free or draining
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = count_reg == CW'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;

    assign cmd.ins  = accept && (req.opcode == OP_INSERT) && !full;
    assign cmd.pop  = accept && (req.opcode == OP_POP) && !empty;
    assign cmd.prio = req.priority_req;

    // Chain of cells; the left end holds the smallest entry, which a pop removes
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        logic [PRIO_W-1:0] left_value;
        logic              left_take;
        logic [PRIO_W-1:0] right_value;

        if (g == 0)
        begin : g_head
            assign left_value = '0;
            assign left_take  = 1'b0;
        end
        else
        begin : g_body
            assign left_value = cell_value[g-1];
            assign left_take  = cell_take[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_value = cell_value[g];
        end
        else
        begin : g_mid
            assign right_value = cell_value[g+1];
        end

        sspq_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .count       (count_reg),
            .left_value  (left_value),
            .left_take   (left_take),
            .right_value (right_value),
            .value       (cell_value[g]),
            .take        (cell_take[g])
        );
    end

    // Work out count and result of the request being transferred
    always_comb
    begin
        count_next  = count_reg;
        popped_next = '0;
        status_next = STATUS_OK;
        if (req.opcode == OP_INSERT)
        begin
            if (full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                popped_next = cell_value[0];
                count_next  = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next transfer in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.popped_priority = popped_reg;
    assign rsp.status          = status_reg;
    assign rsp.occupancy       = occ_reg;

endmodule

@@ rtl/sspq_cell.sv @@
// One slot of the sorted chain: holds one priority and shifts with its neighbors.
// Depends on sspq_pkg.
module sspq_cell import sspq_pkg::*; #(
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic              clk,
    input  cmd_t              cmd,
    input  logic [CW-1:0]     count,
    input  logic [PRIO_W-1:0] left_value,
    input  logic              left_take,
    input  logic [PRIO_W-1:0] right_value,
    output logic [PRIO_W-1:0] value,
    output logic              take
);

    logic [PRIO_W-1:0] value_reg;
    logic              occupied;

    assign occupied = count > CW'(IDX);
    // Take the new entry, or make room for it, when empty or strictly greater
    assign take     = !occupied || (value_reg > cmd.prio);
    assign value    = value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            value_reg <= right_value;
        end
        else if (cmd.ins && take)
        begin
            value_reg <= left_take ? left_value : cmd.prio;
        end
    end

endmodule

@@ rtl/sspq_checker.sv @@
// Port-level checks of the priority queue, bound to the top level.
// Depends on sspq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sspq_checker import sspq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [PRIO_W-1:0] popped_priority,
    input logic [1:0]        status,
    input logic [OCC_W-1:0]  occupancy
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

    // Response stays up until it is transferred
    `ASSERT_CLK(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid)

    // A stalled response blocks any new request
    `ASSERT_CLK(a_no_overrun, clk, rst_n, rsp_valid && !rsp_ready |-> !(req_valid && req_ready))

    // Pop from empty leaves nothing and returns zero
    `ASSERT_CLK(a_empty_pop, clk, rst_n,
        rsp_valid && status == STATUS_EMPTY |-> occupancy == '0 && popped_priority == '0)

    // A dropped insert only happens at full occupancy
    `ASSERT_CLK(a_full_drop, clk, rst_n,
        rsp_valid && status == STATUS_FULL |-> occupancy == FULL_OCC && popped_priority == '0)

endmodule

bind stable_sorted_priority_queue sspq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sspq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .popped_priority (rsp.popped_priority),
    .status          (rsp.status),
    .occupancy       (rsp.occupancy)
);

@@ sim/stable_sorted_priority_queue_tb.sv @@
// Self-checking testbench for the stable sorted priority queue.
// Depends on sspq_pkg, sspq_req_if/sspq_rsp_if and the stable_sorted_priority_queue RTL.
module stable_sorted_priority_queue_tb;
    import sspq_pkg::*;

    localparam int QUEUE_DEPTH  = DEFAULT_DEPTH;
    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_TAIL   = 150;     // last transfers run with no idling
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic              opcode;
        logic [PRIO_W-1:0] prio;
    } queue_cmd_t;

    typedef struct {
        logic [PRIO_W-1:0] popped;
        status_t           status;
        logic [OCC_W-1:0]  occ;
    } queue_rsp_t;

    logic clk;
    logic rst_n;

    sspq_req_if req_ch ();
    sspq_rsp_if rsp_ch ();

    stable_sorted_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // Operations waiting for transfer, and results predicted but not yet seen
    queue_cmd_t pending_cmds[$];
    queue_rsp_t expected_rsps[$];

    // Shadow of the queue contents, updated on every accepted request
    logic [PRIO_W-1:0] held_prio[QUEUE_DEPTH];
    int held_count = 0;

    int total_items   = 0;
    int sent_items    = 0;
    int checked_rsps  = 0;
    int mismatches    = 0;
    int insert_ops    = 0;
    int pop_ops       = 0;
    int empty_pops    = 0;
    int full_drops    = 0;
    int peak_count    = 0;

    int src_gap       = 0;
    int src_idle_pct  = 20;
    int snk_gap       = 0;
    int snk_idle_pct  = 20;

    // Clock, plus known values on every input from time zero
    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.opcode   = OP_INSERT;
        req_ch.priority_req = '0;
        rsp_ch.ready    = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one operation to the shadow queue and record the result it must give.
    // A new entry goes after every entry less than or equal to it, which keeps
    // equal priorities in arrival order.
    function automatic void apply_cmd(input queue_cmd_t cmd);
        queue_rsp_t r;
        int         pos;
        r.popped = '0;
        r.status = STATUS_OK;
        if (cmd.opcode == OP_INSERT)
        begin
            insert_ops++;
            if (held_count >= QUEUE_DEPTH)
            begin
                // full: drop the entry, leave the state alone
                r.status = STATUS_FULL;
                full_drops++;
            end
            else
            begin
                pos = 0;
                while (pos < held_count && held_prio[pos] <= cmd.prio)
                    pos++;
                for (int i = held_count; i > pos; i--)
                    held_prio[i] = held_prio[i-1];
                held_prio[pos] = cmd.prio;
                held_count++;
            end
        end
        else
        begin
            pop_ops++;
            if (held_count == 0)
            begin
                r.status = STATUS_EMPTY;
                empty_pops++;
            end
            else
            begin
                r.popped = held_prio[0];
                for (int i = 1; i < held_count; i++)
                    held_prio[i-1] = held_prio[i];
                held_count--;
            end
        end
        if (held_count > peak_count)
            peak_count = held_count;
        r.occ = held_count[OCC_W-1:0];
        expected_rsps.push_back(r);
    endfunction

    task automatic add_cmd(input logic op, input logic [PRIO_W-1:0] prio);
        queue_cmd_t c;
        c.opcode = op;
        c.prio   = prio;
        pending_cmds.push_back(c);
    endtask

    // Mix small values (many ties), the extremes, and full-range values
    function automatic logic [PRIO_W-1:0] pick_prio();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return $urandom_range(0, 7);
        else if (sel < 35)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return 32'h0000_0001;
                default: return 32'hFFFF_FFFE;
            endcase
        end
        return $urandom;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // Driver: advance on each transfer, hold while stalled, idle in bursts
    always @(posedge clk)
    begin : drive_req
        logic next_valid;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            next_valid = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                apply_cmd(pending_cmds.pop_front());
                sent_items++;
                next_valid = 1'b0;
                if (sent_items % 100 == 0)
                    src_idle_pct = pick_idle_pct();
            end
            if (!next_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_cmds.size() > 0)
                begin
                    if (sent_items + QUIET_TAIL < total_items &&
                        $urandom_range(0, 99) < src_idle_pct)
                        src_gap = $urandom_range(0, 3);
                    else
                    begin
                        next_valid = 1'b1;
                        req_ch.opcode       <= pending_cmds[0].opcode;
                        req_ch.priority_req <= pending_cmds[0].prio;
                    end
                end
            end
            req_ch.valid <= next_valid;
        end
    end

    // Monitor: check each response transfer against the oldest prediction,
    // and stall the response side in random bursts
    always @(posedge clk)
    begin : watch_rsp
        queue_rsp_t want;
        logic       next_ready;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response popped=%h status=%0d occupancy=%0d",
                             $time, rsp_ch.popped_priority, rsp_ch.status,
                             rsp_ch.occupancy);
                    mismatches++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    checked_rsps++;
                    if (rsp_ch.popped_priority !== want.popped)
                    begin
                        $display("%0t: popped_priority expected %h actual %h",
                                 $time, want.popped, rsp_ch.popped_priority);
                        mismatches++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.occupancy !== want.occ)
                    begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occ, rsp_ch.occupancy);
                        mismatches++;
                    end
                end
                if (checked_rsps % 100 == 0)
                    snk_idle_pct = pick_idle_pct();
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                next_ready = 1'b0;
            end
            else if (sent_items + QUIET_TAIL < total_items &&
                     $urandom_range(0, 99) < snk_idle_pct)
            begin
                snk_gap = $urandom_range(0, 3);
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
            rsp_ch.ready <= next_ready;
        end
    end

    // Stimulus, reset, and end of run
    initial
    begin : run_test
        int phase;
        int span;
        int insert_pct;
        int base;

        // Directed: pop on empty, extremes, ties, pop carrying a stray priority
        add_cmd(OP_POP, 32'hDEAD_BEEF);
        add_cmd(OP_INSERT, 32'hFFFF_FFFF);
        add_cmd(OP_INSERT, 32'h0000_0000);
        add_cmd(OP_INSERT, 32'h8000_0000);
        add_cmd(OP_INSERT, 32'd5);
        add_cmd(OP_INSERT, 32'd5);
        add_cmd(OP_INSERT, 32'h7FFF_FFFF);
        add_cmd(OP_INSERT, 32'd5);
        add_cmd(OP_INSERT, 32'hAAAA_AAAA);
        add_cmd(OP_INSERT, 32'h5555_5555);
        for (int i = 0; i < 10; i++)
            add_cmd(OP_POP, '1);
        add_cmd(OP_POP, '0);

        // Fill past full, then drain past empty, with random content
        for (int i = 0; i < QUEUE_DEPTH + 6; i++)
            add_cmd(OP_INSERT, pick_prio());
        for (int i = 0; i < QUEUE_DEPTH + 6; i++)
            add_cmd(OP_POP, $urandom);

        // Random phases biased toward filling, draining, or churning in between
        base = pending_cmds.size();
        while (pending_cmds.size() < base + RANDOM_ITEMS)
        begin
            phase = $urandom_range(0, 2);
            span  = $urandom_range(20, 150);
            insert_pct = (phase == 0) ? 85 : (phase == 1) ? 15 : 50;
            for (int i = 0; i < span; i++)
            begin
                if ($urandom_range(0, 99) < insert_pct)
                    add_cmd(OP_INSERT, pick_prio());
                else
                    add_cmd(OP_POP, $urandom);
            end
        end
        total_items = pending_cmds.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_items < total_items)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operations: %0d inserts (%0d dropped full), %0d pops (%0d on empty).",
                 total_items, insert_ops, full_drops, pop_ops, empty_pops);
        $display("Checked %0d responses; peak occupancy %0d of %0d.",
                 checked_rsps, peak_count, QUEUE_DEPTH);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("Timeout: %0d of %0d requests sent, %0d responses outstanding",
                 sent_items, total_items, expected_rsps.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
